// File: rtl/core/rbks_pkg.sv
// rbks_pkg: shared types and constants for the record block key search
// no dependencies; used by record_block_key_search_top and its testbench
`default_nettype none

package rbks_pkg;

  localparam int BYTE_W = 8;
  localparam int FC_W   = 32;  // field counter, also holds value lengths
  localparam int LEN_W  = 32;  // kept part of the record length field
  localparam int MKL_W  = 7;   // matched key length on the result

  typedef enum logic [1:0] {
    FUNC_START = 2'd0,
    FUNC_KEY   = 2'd1,
    FUNC_DATA  = 2'd2
  } func_t;

  typedef enum logic [1:0] {
    ST_VALUE     = 2'd0,
    ST_EMPTY     = 2'd1,
    ST_NOT_FOUND = 2'd2
  } status_t;

  typedef enum logic [2:0] {
    PH_LEN    = 3'd0,
    PH_KEYLEN = 3'd1,
    PH_KEY    = 3'd2,
    PH_FLAGS  = 3'd3,
    PH_VALUE  = 3'd4,
    PH_SKIP   = 3'd5
  } phase_t;

endpackage

`default_nettype wire

// File: rtl/core/rbks_ram.sv
// rbks_ram: generic single write port, single read port ram
// registered read, read-first on address collision; no package dependency
`default_nettype none

module rbks_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic [AW-1:0]    raddr,
  output logic      [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rd_data_r <= mem_r[raddr];
  end

  assign rdata = rd_data_r;

endmodule

`default_nettype wire

// File: rtl/core/record_block_key_search_top.sv
// record_block_key_search_top: streams one block of length-prefixed records and
// returns the value of the first record whose key equals the search key
// an input transfer passes through the input register, then the result register
// throughput: one item per cycle while the result side keeps taking transfers
// reset: rst_n synchronous active low; parser state and handshakes cleared,
// key ram contents are undefined until written by key items
// depends on rbks_pkg and rbks_ram
`default_nettype none

module record_block_key_search_top #(
  parameter int KEY_MAX_BYTES      = 64,
  parameter int LENGTH_FIELD_BYTES = 4
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  // input channel
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [7:0]  in_tdata,   // [7:0] byte_in
  input  wire logic [1:0]  in_tuser,   // [1:0] func
  input  wire logic        in_tlast,   // block_end
  // result channel
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [23:0]      out_tdata,  // [7:0] value_byte, [15:8] record_flags,
                                       // [22:16] matched_key_length, [23] zero
  output logic [1:0]       out_tuser,  // [1:0] status
  output logic             out_tlast   // run_last
);

  localparam int BYTE_W = rbks_pkg::BYTE_W;
  localparam int FC_W   = rbks_pkg::FC_W;
  localparam int LEN_W  = rbks_pkg::LEN_W;
  localparam int MKL_W  = rbks_pkg::MKL_W;

  // key ram index and key length widths follow the key capacity
  localparam int KIDX_W = (KEY_MAX_BYTES > 1) ? $clog2(KEY_MAX_BYTES) : 1;
  localparam int KL_W   = $clog2(KEY_MAX_BYTES + 1);

  localparam logic [KL_W-1:0]  KEY_MAX_KL  = KL_W'(KEY_MAX_BYTES);
  localparam logic [FC_W-1:0]  KEY_MAX_FC  = FC_W'(KEY_MAX_BYTES);
  localparam logic [FC_W-1:0]  LEN_BYTES   = FC_W'(LENGTH_FIELD_BYTES);
  // header bytes besides the key: length field, key length, flags
  localparam logic [LEN_W-1:0] HDR_BASE    = LEN_W'(LENGTH_FIELD_BYTES + 2);

  // ---------------------------------------------------------------------
  // input register
  // ---------------------------------------------------------------------
  logic                in_vld_r;
  rbks_pkg::func_t     func_r;
  logic [BYTE_W-1:0]   byte_r;
  logic                end_r;

  logic                out_vld_r;
  logic                out_free;
  logic                proc_go;

  // an item is processed once the result register can take whatever it yields
  assign out_free  = !out_vld_r || out_tready;
  assign proc_go   = in_vld_r && out_free;
  assign in_tready = !in_vld_r || proc_go;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r <= 1'b0;
    end else if (in_tvalid && in_tready) begin
      in_vld_r <= 1'b1;
    end else if (proc_go) begin
      in_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      func_r <= rbks_pkg::func_t'(in_tuser);
      byte_r <= in_tdata;
      end_r  <= in_tlast;
    end
  end

  // ---------------------------------------------------------------------
  // parser state
  // ---------------------------------------------------------------------
  rbks_pkg::phase_t    phase_r, phase_nxt;
  logic [FC_W-1:0]     fc_r, fc_nxt;
  logic [LEN_W-1:0]    rl_r, rl_nxt;
  logic [BYTE_W-1:0]   cand_r, cand_nxt;
  logic                mism_r, mism_nxt;
  logic                fin_r, fin_nxt;
  logic [BYTE_W-1:0]   flags_r, flags_nxt;
  logic [KL_W-1:0]     key_len_r, key_len_nxt;

  // key store: written at the key length on appends, read each cycle at the
  // counter value the next processed item will see
  logic                key_we;
  logic [KIDX_W-1:0]   key_waddr;
  logic [KIDX_W-1:0]   key_raddr;
  logic [BYTE_W-1:0]   key_rdata;
  logic                byp_r;
  logic [BYTE_W-1:0]   byp_data_r;
  logic [BYTE_W-1:0]   key_byte;

  assign key_waddr = key_len_r[KIDX_W-1:0];
  assign key_raddr = fc_nxt[KIDX_W-1:0];

  rbks_ram #(
    .WIDTH (BYTE_W),
    .DEPTH (KEY_MAX_BYTES)
  ) u_key_ram (
    .clk   (clk),
    .we    (key_we),
    .waddr (key_waddr),
    .wdata (byte_r),
    .raddr (key_raddr),
    .rdata (key_rdata)
  );

  // forward a key byte written in the same cycle as the read of its entry
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      byp_r <= 1'b0;
    end else begin
      byp_r <= key_we && (key_waddr == key_raddr);
    end
  end

  always_ff @(posedge clk) begin
    byp_data_r <= byte_r;
  end

  assign key_byte = byp_r ? byp_data_r : key_rdata;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r   <= rbks_pkg::PH_LEN;
      fc_r      <= '0;
      rl_r      <= '0;
      cand_r    <= '0;
      mism_r    <= 1'b0;
      fin_r     <= 1'b0;
      flags_r   <= '0;
      key_len_r <= '0;
    end else begin
      phase_r   <= phase_nxt;
      fc_r      <= fc_nxt;
      rl_r      <= rl_nxt;
      cand_r    <= cand_nxt;
      mism_r    <= mism_nxt;
      fin_r     <= fin_nxt;
      flags_r   <= flags_nxt;
      key_len_r <= key_len_nxt;
    end
  end

  // ---------------------------------------------------------------------
  // next state and result
  // ---------------------------------------------------------------------
  logic                res_vld;
  rbks_pkg::status_t   res_status;
  logic [BYTE_W-1:0]   res_value;
  logic                res_match;
  logic                res_last;
  logic                end_check;

  logic [FC_W-1:0]     fc_inc;
  logic [FC_W-1:0]     fc_dec;
  logic [LEN_W-1:0]    hdr_len;
  logic [LEN_W-1:0]    val_len;
  logic [LEN_W-1:0]    rl_base;
  logic                key_cmp_ok;

  assign fc_inc  = fc_r + FC_W'(1);
  assign fc_dec  = fc_r - FC_W'(1);
  assign hdr_len = HDR_BASE + LEN_W'(cand_r);
  // value length, zero for a record shorter than its header
  assign val_len = (rl_r > hdr_len) ? (rl_r - hdr_len) : '0;
  assign rl_base = (fc_r == '0) ? '0 : rl_r;
  // only entries below the search key length take part in the compare
  assign key_cmp_ok = (fc_r < FC_W'(key_len_r)) && (fc_r < KEY_MAX_FC);

  always_comb begin
    phase_nxt   = phase_r;
    fc_nxt      = fc_r;
    rl_nxt      = rl_r;
    cand_nxt    = cand_r;
    mism_nxt    = mism_r;
    fin_nxt     = fin_r;
    flags_nxt   = flags_r;
    key_len_nxt = key_len_r;
    key_we      = 1'b0;
    res_vld     = 1'b0;
    res_status  = rbks_pkg::ST_NOT_FOUND;
    res_value   = '0;
    res_match   = 1'b0;
    res_last    = 1'b0;
    end_check   = 1'b0;

    if (proc_go) begin
      unique case (func_r)
        rbks_pkg::FUNC_START: begin
          phase_nxt   = rbks_pkg::PH_LEN;
          fc_nxt      = '0;
          rl_nxt      = '0;
          cand_nxt    = '0;
          mism_nxt    = 1'b0;
          fin_nxt     = 1'b0;
          flags_nxt   = '0;
          key_len_nxt = '0;
        end
        rbks_pkg::FUNC_KEY: begin
          // appends beyond the key capacity are dropped
          if (key_len_r < KEY_MAX_KL) begin
            key_we      = 1'b1;
            key_len_nxt = key_len_r + KL_W'(1);
          end
        end
        rbks_pkg::FUNC_DATA: begin
          if (!fin_r) begin
            end_check = 1'b1;
            unique case (phase_r)
              rbks_pkg::PH_LEN: begin
                rl_nxt = rl_base;
                for (int i = 0; i < 4; i++) begin
                  if (fc_r == FC_W'(i)) begin
                    rl_nxt[8*i +: 8] = byte_r;
                  end
                end
                fc_nxt = fc_inc;
                if (fc_inc >= LEN_BYTES) begin
                  fc_nxt    = '0;
                  phase_nxt = rbks_pkg::PH_KEYLEN;
                end
              end
              rbks_pkg::PH_KEYLEN: begin
                cand_nxt  = byte_r;
                mism_nxt  = (byte_r != BYTE_W'(key_len_r));
                fc_nxt    = '0;
                phase_nxt = (byte_r != '0) ? rbks_pkg::PH_KEY : rbks_pkg::PH_FLAGS;
              end
              rbks_pkg::PH_KEY: begin
                if (!key_cmp_ok || (key_byte != byte_r)) begin
                  mism_nxt = 1'b1;
                end
                fc_nxt = fc_inc;
                if (fc_inc >= FC_W'(cand_r)) begin
                  fc_nxt    = '0;
                  phase_nxt = rbks_pkg::PH_FLAGS;
                end
              end
              rbks_pkg::PH_FLAGS: begin
                flags_nxt = byte_r;
                fc_nxt    = FC_W'(val_len);
                if (!mism_r) begin
                  end_check = 1'b0;
                  if ((val_len == '0) || end_r) begin
                    // empty or cut-off value: one match report
                    fin_nxt    = 1'b1;
                    res_vld    = 1'b1;
                    res_status = rbks_pkg::ST_EMPTY;
                    res_match  = 1'b1;
                    res_last   = 1'b1;
                    fc_nxt     = fc_r;
                  end else begin
                    phase_nxt = rbks_pkg::PH_VALUE;
                  end
                end else begin
                  phase_nxt = (val_len == '0) ? rbks_pkg::PH_LEN : rbks_pkg::PH_SKIP;
                end
              end
              rbks_pkg::PH_VALUE: begin
                end_check  = 1'b0;
                fc_nxt     = fc_dec;
                res_vld    = 1'b1;
                res_status = rbks_pkg::ST_VALUE;
                res_value  = byte_r;
                res_match  = 1'b1;
                res_last   = (fc_dec == '0) || end_r;
                if (res_last) begin
                  fin_nxt = 1'b1;
                end
              end
              default: begin
                // skipping the value of a record that did not match
                fc_nxt = fc_dec;
                if (fc_dec == '0) begin
                  phase_nxt = rbks_pkg::PH_LEN;
                end
              end
            endcase

            // block ended with no match reported
            if (end_check && end_r) begin
              fin_nxt    = 1'b1;
              res_vld    = 1'b1;
              res_status = rbks_pkg::ST_NOT_FOUND;
              res_value  = '0;
              res_match  = 1'b0;
              res_last   = 1'b1;
            end
          end
        end
        default: begin
          // unused func code, dropped
        end
      endcase
    end
  end

  // ---------------------------------------------------------------------
  // result register
  // ---------------------------------------------------------------------
  logic [1:0]          out_status_r;
  logic [BYTE_W-1:0]   out_value_r;
  logic [BYTE_W-1:0]   out_flags_r;
  logic [MKL_W-1:0]    out_mkl_r;
  logic                out_last_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (proc_go && res_vld) begin
      out_vld_r <= 1'b1;
    end else if (out_tready) begin
      out_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (proc_go && res_vld) begin
      out_status_r <= res_status;
      out_value_r  <= res_value;
      out_flags_r  <= res_match ? flags_nxt : '0;
      out_mkl_r    <= res_match ? cand_nxt[MKL_W-1:0] : '0;
      out_last_r   <= res_last;
    end
  end

  assign out_tvalid = out_vld_r;
  assign out_tdata  = {1'b0, out_mkl_r, out_flags_r, out_value_r};
  assign out_tuser  = out_status_r;
  assign out_tlast  = out_last_r;

  // ---------------------------------------------------------------------
  // checks
  // ---------------------------------------------------------------------
  a_key_len_bound: assert property (@(posedge clk) disable iff (!rst_n)
    key_len_r <= KEY_MAX_KL)
    else $error("search key length beyond capacity");

  a_not_found_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && (out_tuser == rbks_pkg::ST_NOT_FOUND) |-> out_tlast)
    else $error("not-found result without run_last");

  a_last_finishes: assert property (@(posedge clk) disable iff (!rst_n)
    proc_go && res_vld && res_last |=> fin_r)
    else $error("final result did not finish the search");

  a_value_count: assert property (@(posedge clk) disable iff (!rst_n)
    (phase_r == rbks_pkg::PH_VALUE) && !fin_r |-> (fc_r != '0))
    else $error("value phase open with no bytes left");

endmodule

`default_nettype wire

// File: sim/record_block_key_search_top_tb.sv
// record_block_key_search_top_tb: self-checking bench for the record block key search,
// streams searches of random records through the block and checks every result transfer
// depends on rbks_pkg and record_block_key_search_top
`timescale 1ns / 1ps

module record_block_key_search_top_tb;

  localparam int KEY_MAX     = 64;
  localparam int LEN_BYTES   = 4;
  localparam int ITEM_TARGET = 1100;
  localparam int QUIET_TAIL  = 150;     // last transfers run with no idling
  localparam int CYCLE_LIMIT = 400000;
  localparam int PRINT_CAP   = 100;
  localparam logic [1:0] FUNC_UNUSED = 2'd3;

  typedef struct packed {
    logic [1:0] func;
    logic [7:0] data;
    logic       last;
  } search_item_t;

  typedef struct packed {
    rbks_pkg::status_t status;
    logic [7:0]        value;
    logic [7:0]        flags;
    logic [6:0]        key_len;
    logic              last;
  } search_result_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [7:0]  in_tdata = '0;   // [7:0] byte_in
  logic [1:0]  in_tuser = '0;   // [1:0] func
  logic        in_tlast = 1'b0; // block_end
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [23:0] out_tdata;       // [7:0] value_byte, [15:8] record_flags,
                                // [22:16] matched_key_length, [23] zero
  logic [1:0]  out_tuser;       // [1:0] status
  logic        out_tlast;       // run_last

  record_block_key_search_top #(
    .KEY_MAX_BYTES      (KEY_MAX),
    .LENGTH_FIELD_BYTES (LEN_BYTES)
  ) DUT (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

  initial begin
    forever #6 clk = ~clk;
  end

  // stimulus and expected results
  search_item_t   pending_items[$];
  search_result_t expected_results[$];
  search_item_t   cur_item;
  int useful_items = 0;
  int items_total = 0;
  int items_accepted = 0;
  int error_count = 0;
  int cycle_count = 0;
  int in_gap = 0;
  int out_stall = 0;
  bit item_taken = 1'b0;
  bit in_idle_on = 1'b1;
  bit out_idle_on = 1'b1;

  // search state mirrored from the block
  logic [7:0]       key_mem [KEY_MAX];
  logic [6:0]       key_len = '0;
  rbks_pkg::phase_t phase = rbks_pkg::PH_LEN;
  logic [31:0]      fcount = '0;
  logic [31:0]      rec_len = '0;
  logic [7:0]       cand_len = '0;
  logic             key_bad = 1'b0;
  logic             search_done = 1'b0;
  logic [7:0]       held_flags = '0;

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    if (error_count < PRINT_CAP)
      $display("%0t ns mismatch: %s got 0x%0h want 0x%0h", $time, what, got, want);
    error_count++;
  endtask

  task automatic check_field(input string name, input logic [31:0] got,
                             input logic [31:0] want);
    if (got !== want) report_mismatch(name, got, want);
  endtask

  // walks one accepted transfer through the record parser and queues any result
  task automatic predict_item(input search_item_t it);
    logic [31:0]    hdr;
    logic [31:0]    vlen;
    search_result_t r;
    bit             owned;
    owned = 1'b0;
    r = '0;
    case (it.func)
      rbks_pkg::FUNC_START: begin
        key_len = '0;
        phase = rbks_pkg::PH_LEN;
        fcount = '0;
        rec_len = '0;
        cand_len = '0;
        key_bad = 1'b0;
        search_done = 1'b0;
        held_flags = '0;
      end
      rbks_pkg::FUNC_KEY: begin
        // appends past the key store are dropped
        if (key_len < KEY_MAX) begin
          key_mem[key_len] = it.data;
          key_len = key_len + 1'b1;
        end
      end
      rbks_pkg::FUNC_DATA: begin
        if (!search_done) begin
          case (phase)
            rbks_pkg::PH_LEN: begin
              if (fcount == 0) rec_len = '0;
              // only the low four length bytes are kept
              if (fcount < 4) rec_len = rec_len | ({24'd0, it.data} << (8 * fcount));
              fcount = fcount + 1;
              if (fcount >= LEN_BYTES) begin
                fcount = '0;
                phase = rbks_pkg::PH_KEYLEN;
              end
            end
            rbks_pkg::PH_KEYLEN: begin
              cand_len = it.data;
              key_bad = (it.data != {1'b0, key_len});
              fcount = '0;
              phase = (it.data != 0) ? rbks_pkg::PH_KEY : rbks_pkg::PH_FLAGS;
            end
            rbks_pkg::PH_KEY: begin
              if (fcount < key_len && fcount < KEY_MAX) begin
                if (key_mem[fcount] != it.data) key_bad = 1'b1;
              end else begin
                key_bad = 1'b1;
              end
              fcount = fcount + 1;
              if (fcount >= cand_len) begin
                fcount = '0;
                phase = rbks_pkg::PH_FLAGS;
              end
            end
            rbks_pkg::PH_FLAGS: begin
              held_flags = it.data;
              hdr = LEN_BYTES + 2 + cand_len;
              // a length shorter than the header ends the record at its header
              vlen = (rec_len > hdr) ? rec_len - hdr : '0;
              if (!key_bad) begin
                owned = 1'b1;
                if (vlen == 0 || it.last) begin
                  // empty value, or the block cut off right after the flags
                  search_done = 1'b1;
                  r.status = rbks_pkg::ST_EMPTY;
                  r.flags = held_flags;
                  r.key_len = cand_len[6:0];
                  r.last = 1'b1;
                  expected_results.push_back(r);
                end else begin
                  fcount = vlen;
                  phase = rbks_pkg::PH_VALUE;
                end
              end else begin
                fcount = vlen;
                phase = (vlen == 0) ? rbks_pkg::PH_LEN : rbks_pkg::PH_SKIP;
              end
            end
            rbks_pkg::PH_VALUE: begin
              owned = 1'b1;
              fcount = fcount - 1;
              r.status = rbks_pkg::ST_VALUE;
              r.value = it.data;
              r.flags = held_flags;
              r.key_len = cand_len[6:0];
              r.last = (fcount == 0) || it.last;
              if (r.last) search_done = 1'b1;
              expected_results.push_back(r);
            end
            default: begin
              fcount = fcount - 1;
              if (fcount == 0) phase = rbks_pkg::PH_LEN;
            end
          endcase
          // block over with no match, header cuts included
          if (!owned && it.last) begin
            search_done = 1'b1;
            r = '0;
            r.status = rbks_pkg::ST_NOT_FOUND;
            r.last = 1'b1;
            expected_results.push_back(r);
          end
        end
      end
      default: ;
    endcase
  endtask

  task automatic push_item(input logic [1:0] f, input logic [7:0] d, input logic l,
                           input bit counts);
    search_item_t it;
    it.func = f;
    it.data = d;
    it.last = l;
    pending_items.push_back(it);
    if (counts) useful_items++;
  endtask

  // one search: optional start, key bytes, then a block of records
  // match_at picks the record carrying the search key (-1 for none)
  // cut: 0 keeps the whole block, -1 cuts at random, else keeps that many bytes
  // wild adds odd record shapes, stray items and bytes after the block
  task automatic emit_search(input bit with_start, input int key_bytes, input int n_rec,
                             input int match_at, input int match_vlen, input int cut,
                             input bit wild);
    logic [7:0]  key_q[$];
    logic [7:0]  blk[$];
    logic [31:0] total;
    logic [7:0]  b;
    int          klen, vlen, pos, flip_bit, sel, n;
    bit          copy_key, near;
    if (with_start)
      push_item(rbks_pkg::FUNC_START, 8'($urandom_range(0, 255)),
                1'($urandom_range(0, 1)), 1);
    for (int i = 0; i < key_bytes; i++) begin
      b = 8'($urandom_range(0, 255));
      push_item(rbks_pkg::FUNC_KEY, b, 1'($urandom_range(0, 1)), 1);
      if (key_q.size() < KEY_MAX) key_q.push_back(b);
    end
    for (int r = 0; r < n_rec; r++) begin
      copy_key = 1'b0;
      near = 1'b0;
      if (r == match_at) begin
        klen = key_q.size();
        vlen = match_vlen;
        copy_key = 1'b1;
      end else begin
        sel = $urandom_range(0, 19);
        if (sel == 0) begin
          // candidate key longer than the key store
          klen = ($urandom_range(0, 4) == 0) ? 255 : KEY_MAX + $urandom_range(1, 20);
        end else if (sel <= 5) begin
          klen = key_q.size();
          copy_key = 1'b1;
          near = ($urandom_range(0, 1) != 0);
        end else begin
          klen = $urandom_range(0, 6);
        end
        vlen = $urandom_range(0, 6);
      end
      pos = (klen > 0) ? $urandom_range(0, klen - 1) : 0;
      flip_bit = $urandom_range(0, 7);
      total = LEN_BYTES + 2 + klen + vlen;
      if (wild && vlen == 0 && $urandom_range(0, 2) == 0)
        total = $urandom_range(0, LEN_BYTES + 2 + klen);
      else if (wild && r == n_rec - 1 && $urandom_range(0, 3) == 0)
        total = $urandom | 32'h0100_0000;   // never completes before the block ends
      for (int i = 0; i < LEN_BYTES; i++) blk.push_back(total[8 * i +: 8]);
      blk.push_back(klen[7:0]);
      for (int i = 0; i < klen; i++) begin
        b = (copy_key && i < key_q.size()) ? key_q[i] : 8'($urandom_range(0, 255));
        if (near && i == pos) b = b ^ (8'h01 << flip_bit);
        blk.push_back(b);
      end
      blk.push_back(8'($urandom_range(0, 255)));
      for (int i = 0; i < vlen; i++) blk.push_back(8'($urandom_range(0, 255)));
    end
    if (cut < 0) cut = $urandom_range(1, blk.size());
    if (cut > 0) while (blk.size() > cut) blk.delete(blk.size() - 1);
    for (int i = 0; i < blk.size(); i++) begin
      if (wild && $urandom_range(0, 23) == 0) begin
        if ($urandom_range(0, 1))
          push_item(rbks_pkg::FUNC_KEY, 8'($urandom_range(0, 255)), 1'b0, 1);
        else
          push_item(FUNC_UNUSED, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)), 0);
      end
      push_item(rbks_pkg::FUNC_DATA, blk[i], i == blk.size() - 1, 1);
    end
    // the search is over, these bytes are dropped
    if (wild && $urandom_range(0, 3) == 0) begin
      n = $urandom_range(1, 3);
      for (int i = 0; i < n; i++)
        push_item(rbks_pkg::FUNC_DATA, 8'($urandom_range(0, 255)),
                  1'($urandom_range(0, 1)), 0);
    end
  endtask

  task automatic emit_random_search();
    int sel, key_bytes, n_rec, match_at, match_vlen;
    sel = $urandom_range(0, 9);
    if (sel == 0) key_bytes = 0;
    else if (sel == 1) key_bytes = KEY_MAX + $urandom_range(0, 4);
    else if (sel == 2) key_bytes = $urandom_range(9, KEY_MAX);
    else key_bytes = $urandom_range(1, 8);
    n_rec = $urandom_range(1, 4);
    match_at = ($urandom_range(0, 3) == 0) ? -1 : $urandom_range(0, n_rec - 1);
    match_vlen = ($urandom_range(0, 5) == 0) ? 0 : $urandom_range(1, 8);
    emit_search(1'b1, key_bytes, n_rec, match_at, match_vlen,
                ($urandom_range(0, 3) == 0) ? -1 : 0, $urandom_range(0, 3) != 0);
  endtask

  // input side: accepted transfers go through the predictor
  always @(posedge clk) begin
    if (rst_n && in_tvalid && in_tready) begin
      predict_item(cur_item);
      items_accepted++;
      item_taken = 1'b1;
      // switch between stretches with and without idling
      if (items_accepted % 64 == 0) begin
        in_idle_on = $urandom_range(0, 2) != 0;
        out_idle_on = $urandom_range(0, 2) != 0;
      end
      if (items_accepted + QUIET_TAIL >= items_total) begin
        in_idle_on = 1'b0;
        out_idle_on = 1'b0;
      end
      if (in_idle_on && $urandom_range(0, 3) == 0) in_gap = $urandom_range(1, 19);
    end
  end

  // driver: presents the next pending item once the current one has transferred
  always @(negedge clk) begin
    if (rst_n && (!in_tvalid || item_taken)) begin
      item_taken = 1'b0;
      if (in_gap != 0 || pending_items.size() == 0) begin
        if (in_gap != 0) in_gap--;
        in_tvalid <= 1'b0;
      end else begin
        cur_item = pending_items.pop_front();
        in_tdata <= cur_item.data;
        in_tuser <= cur_item.func;
        in_tlast <= cur_item.last;
        in_tvalid <= 1'b1;
      end
    end
  end

  // result side backpressure in bursts
  always @(negedge clk) begin
    if (out_stall != 0) begin
      out_stall--;
      out_tready <= 1'b0;
    end else begin
      out_tready <= 1'b1;
      if (out_idle_on && $urandom_range(0, 5) == 0) out_stall = $urandom_range(1, 19);
    end
  end

  // monitor: each result transfer against the oldest expected one
  always @(posedge clk) begin : result_monitor
    search_result_t want;
    if (rst_n && out_tvalid && out_tready) begin
      if (expected_results.size() == 0) begin
        report_mismatch("result with nothing expected",
                        32'({out_tuser, out_tlast, out_tdata}), 0);
      end else begin
        want = expected_results.pop_front();
        check_field("status", 32'(out_tuser), 32'(want.status));
        check_field("value_byte", 32'(out_tdata[7:0]), 32'(want.value));
        check_field("record_flags", 32'(out_tdata[15:8]), 32'(want.flags));
        check_field("matched_key_length", 32'(out_tdata[22:16]), 32'(want.key_len));
        check_field("tdata pad bit", 32'(out_tdata[23]), 0);
        check_field("run_last", 32'(out_tlast), 32'(want.last));
      end
    end
  end

  // hang guard
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  initial begin
    // block bytes before any start: key length zero matches a zero length key
    emit_search(1'b0, 0, 1, 0, 1, 0, 1'b0);
    // one byte key, matching record with an empty value
    emit_search(1'b1, 1, 1, 0, 0, 0, 1'b0);
    // stray unknown func, then a block that ends inside the length field
    push_item(rbks_pkg::FUNC_START, 8'hFF, 1'b1, 1);
    push_item(FUNC_UNUSED, 8'hA5, 1'b0, 0);
    push_item(rbks_pkg::FUNC_DATA, 8'h00, 1'b0, 1);
    push_item(rbks_pkg::FUNC_DATA, 8'hFF, 1'b1, 1);
    // match cut off on its flags byte
    emit_search(1'b1, 0, 1, 0, 3, LEN_BYTES + 2, 1'b0);
    while (useful_items < ITEM_TARGET) emit_random_search();
    items_total = pending_items.size();

    repeat (12) @(negedge clk);
    rst_n <= 1'b1;

    while (items_accepted < items_total || expected_results.size() != 0) @(posedge clk);
    // leave room for anything stray
    repeat (20) @(posedge clk);
    if (error_count == 0 && expected_results.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
